// File: sv/ssu_pkg.sv
// package: request and result types and cell control for the sorted set union
package ssu_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic [POS_W-1:0]          position;
        logic                      run_end;
        logic                      overflow;
    } t_out_res;

    typedef struct packed {
        logic ins;
        logic shl;
    } t_cell_ctl;

endpackage

// File: sv/sorted_set_union_top.sv
// top level: sorted set union built as a chain of insertion cells
//
// requests come in on i_valid / o_ready with i_data (value, final_item).
// every accepted value is compared against all cells in the same cycle and
// either dropped as a duplicate, dropped as overflow when the chain is full,
// or inserted in sorted place while the greater cells shift right by one.
// during loading one request is taken per cycle.
// the request marked final_item is inserted first, then the block stops
// taking requests and reads out the chain lowest value first on
// o_valid / i_ready: one result per cycle while i_ready is high,
// starting the cycle after the final request, with position, run_end on
// the greatest value and the sticky overflow flag. each taken result
// shifts the chain left by one cell.
// when the receiver stalls the head cell simply holds its value.
// after run_end is taken the chain is empty and loading resumes.
// reset empties every cell and clears the overflow flag and readout state.
module sorted_set_union_top #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssu_pkg::t_in_req  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output ssu_pkg::t_out_res o_data
);
    import ssu_pkg::*;

    logic signed [VALUE_W-1:0] c_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    c_valid;
    logic [TABLE_DEPTH-1:0]    c_ge;
    logic [TABLE_DEPTH-1:0]    c_eq;

    t_cell_ctl        ctl;
    logic             in_acc;
    logic             out_acc;
    logic             dup;
    logic             full;
    logic             run_end;

    logic             r_reading;
    logic             n_reading;
    logic             r_ovf;
    logic             n_ovf;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign dup     = |c_eq;
    assign full    = c_valid[TABLE_DEPTH-1];
    assign run_end = !c_valid[1];

    assign ctl.ins = in_acc && !dup && !full;
    assign ctl.shl = out_acc;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic signed [VALUE_W-1:0] left_value;
            logic                      left_valid;
            logic                      left_ge;
            logic signed [VALUE_W-1:0] right_value;
            logic                      right_valid;

            if (g == 0) begin : g_head
                assign left_value = '0;
                assign left_valid = 1'b0;
                assign left_ge    = 1'b0;
            end else begin : g_body
                assign left_value = c_value[g-1];
                assign left_valid = c_valid[g-1];
                assign left_ge    = c_ge[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign right_value = '0;
                assign right_valid = 1'b0;
            end else begin : g_mid
                assign right_value = c_value[g+1];
                assign right_valid = c_valid[g+1];
            end

            ssu_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_new_value   (i_data.value),
                .i_left_value  (left_value),
                .i_left_valid  (left_valid),
                .i_left_ge     (left_ge),
                .i_right_value (right_value),
                .i_right_valid (right_valid),
                .o_value       (c_value[g]),
                .o_valid       (c_valid[g]),
                .o_ge          (c_ge[g]),
                .o_eq          (c_eq[g])
            );
        end
    endgenerate

    assign o_ready          = !r_reading;
    assign o_valid          = r_reading && c_valid[0];
    assign o_data.value_res = c_value[0];
    assign o_data.position  = r_pos;
    assign o_data.run_end   = run_end;
    assign o_data.overflow  = r_ovf;

    always_comb begin
        n_reading = r_reading;
        n_ovf     = r_ovf;
        n_pos     = r_pos;
        if (in_acc) begin
            if (!dup && full) begin
                n_ovf = 1'b1;
            end
            if (i_data.final_item) begin
                n_reading = 1'b1;
                n_pos     = '0;
            end
        end
        if (out_acc) begin
            n_pos = r_pos + POS_W'(1);
            if (run_end) begin
                n_reading = 1'b0;
                n_ovf     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_ovf     <= 1'b0;
            r_pos     <= '0;
        end else begin
            r_reading <= n_reading;
            r_ovf     <= n_ovf;
            r_pos     <= n_pos;
        end
    end

endmodule

// File: sv/ssu_cell.sv
// one cell of the sorted insertion chain: holds one value and its valid bit
module ssu_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssu_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [ssu_pkg::VALUE_W-1:0] i_new_value,
    input  logic signed [ssu_pkg::VALUE_W-1:0] i_left_value,
    input  logic                               i_left_valid,
    input  logic                               i_left_ge,
    input  logic signed [ssu_pkg::VALUE_W-1:0] i_right_value,
    input  logic                               i_right_valid,
    output logic signed [ssu_pkg::VALUE_W-1:0] o_value,
    output logic                               o_valid,
    output logic                               o_ge,
    output logic                               o_eq
);
    import ssu_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      r_valid;
    logic                      n_valid;

    // empty or holding a greater value
    assign o_ge    = !r_valid || (r_value > i_new_value);
    assign o_eq    = r_valid && (r_value == i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.ins && o_ge) begin
            if (i_left_ge) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end else if (i_ctl.shl) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: test/sorted_set_union_top_test.sv
// testbench for sorted_set_union_top: directed and random jobs checked against a union predictor
module sorted_set_union_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssu_pkg::*;

    localparam int DEPTH = 32;
    localparam int TAIL_CYCLES = 2 * DEPTH + 16;
    localparam int PHASE_REQS = 58;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS = 100;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        t_in_req  req;
        logic     chk;
        t_out_res res;
    } t_dir_row;

    typedef struct packed {
        logic     chk;
        t_out_res res;
    } t_typed_res;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_in_req  i_data;
    logic     o_valid;
    logic     i_ready;
    t_out_res o_data;

    logic signed [VALUE_W-1:0] held_vals [$];
    logic                      held_dropped = 1'b0;
    t_out_res                  union_exp_q [$];
    t_typed_res                typed_q [$];
    logic signed [VALUE_W-1:0] job_vals [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ready_hold = 0;
    int err_cnt = 0;
    int req_cnt = 0;
    int job_cnt = 0;
    int res_cnt = 0;
    int ovf_job_cnt = 0;

    // single-value jobs after an empty table carry their obvious answer; other rows use the predictor
    t_dir_row dir_tab [0:15] = '{
        '{'{V_MIN, 1'b1}, 1'b1, '{V_MIN, 6'd0, 1'b1, 1'b0}},
        '{'{V_MAX, 1'b1}, 1'b1, '{V_MAX, 6'd0, 1'b1, 1'b0}},
        '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 6'd0, 1'b1, 1'b0}},
        '{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 6'd0, 1'b1, 1'b0}},
        '{'{32'sd7, 1'b0}, 1'b0, '0},
        '{'{32'sd7, 1'b0}, 1'b0, '0},
        '{'{-32'sd5, 1'b0}, 1'b0, '0},
        '{'{V_MAX, 1'b0}, 1'b0, '0},
        '{'{V_MIN, 1'b0}, 1'b0, '0},
        '{'{32'sd7, 1'b1}, 1'b0, '0},
        '{'{32'sd3, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd2, 1'b1}, 1'b0, '0},
        '{'{32'sh5555_5555, 1'b0}, 1'b0, '0},
        '{'{32'shAAAA_AAAA, 1'b0}, 1'b0, '0},
        '{'{V_MIN, 1'b1}, 1'b0, '0}
    };

    sorted_set_union_top #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (err_cnt < MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        err_cnt++;
    endtask

    function automatic void union_take(input t_in_req r, input t_typed_res tr);
        logic signed [VALUE_W-1:0] v;
        t_out_res                  res;
        int                        pos;
        int                        n;
        v = r.value;
        pos = 0;
        while (pos < held_vals.size() && held_vals[pos] < v) pos++;
        if (!(pos < held_vals.size() && held_vals[pos] == v)) begin
            if (held_vals.size() >= DEPTH) begin
                held_dropped = 1'b1;
            end else begin
                held_vals.insert(pos, v);
            end
        end
        if (r.final_item) begin
            n = held_vals.size();
            if (tr.chk) begin
                union_exp_q.push_back(tr.res);
            end else begin
                for (int k = 0; k < n; k++) begin
                    res.value_res = held_vals[k];
                    res.position  = k[POS_W-1:0];
                    res.run_end   = (k == n - 1);
                    res.overflow  = held_dropped;
                    union_exp_q.push_back(res);
                end
            end
            job_cnt++;
            if (held_dropped) ovf_job_cnt++;
            held_vals.delete();
            held_dropped = 1'b0;
        end
    endfunction

    task automatic check_result(input t_out_res got);
        t_out_res want;
        res_cnt++;
        if (union_exp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d", got.value_res));
        end else begin
            want = union_exp_q.pop_front();
            if (got.value_res !== want.value_res)
                report_mismatch($sformatf("value_res %0d, want %0d",
                                          got.value_res, want.value_res));
            if (got.position !== want.position)
                report_mismatch($sformatf("position %0d, want %0d",
                                          got.position, want.position));
            if (got.run_end !== want.run_end)
                report_mismatch($sformatf("run_end %0b, want %0b", got.run_end, want.run_end));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %0b, want %0b",
                                          got.overflow, want.overflow));
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_typed_res tr;
        if (i_rst_n) begin
            if (o_valid && i_ready) check_result(o_data);
            if (i_valid && o_ready) begin
                tr = '0;
                if (typed_q.size() != 0) tr = typed_q.pop_front();
                union_take(i_data, tr);
            end
        end
    end

    // receiver: random stalls, long hold-off counted here
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    task automatic send_req(input t_in_req r);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (!o_ready);
        req_cnt++;
    endtask

    // first let the last request reach the predictor, then wait until no result is outstanding
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (union_exp_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(input bit wide);
        int kind;
        kind = $urandom_range(9, 0);
        if (wide) kind = (kind == 0) ? 9 : 0;
        case (kind)
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return int'($urandom_range(16, 0)) - 8;
            7: begin
                case ($urandom_range(3, 0))
                    0: return V_MIN;
                    1: return V_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                if (job_vals.size() != 0) return job_vals[$urandom_range(job_vals.size() - 1, 0)];
                return $urandom;
            end
        endcase
    endfunction

    task automatic run_job(input int len);
        t_in_req r;
        bit      wide;
        wide = (len > DEPTH);
        job_vals.delete();
        for (int k = 0; k < len; k++) begin
            r.value      = pick_value(wide);
            r.final_item = (k == len - 1);
            job_vals.push_back(r.value);
            send_req(r);
        end
    endtask

    initial begin
        t_typed_res tr;
        int         goal;
        int         len;
        bit         first;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(dir_tab); k++) begin
            tr.chk = dir_tab[k].chk;
            tr.res = dir_tab[k].res;
            typed_q.push_back(tr);
            send_req(dir_tab[k].req);
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    ready_hold     = HOLD_CYCLES;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            goal  = req_cnt + PHASE_REQS;
            first = 1'b1;
            while (req_cnt < goal) begin
                if ((first && ph[0]) || $urandom_range(9, 0) == 0)
                    len = DEPTH + $urandom_range(10, 1);
                else
                    len = $urandom_range(10, 1);
                run_job(len);
                first = 1'b0;
            end
            // sender holds back until the readout has fully drained
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d requests in %0d jobs, %0d of them overflowing the table",
                 req_cnt, job_cnt, ovf_job_cnt);
        $display("checked %0d results over four idle/stall mixes and a long receiver hold",
                 res_cnt);
        if (err_cnt == 0 && union_exp_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", union_exp_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
sv/ssu_pkg.sv
sv/ssu_cell.sv
sv/sorted_set_union_top.sv
test/sorted_set_union_top_test.sv
